/* src/gjk_pkg.sv */
package gjk_pkg;

  // Store geometry and coordinate format.
  localparam int MAX_VERTICES = 64;
  localparam int COORD_BITS   = 12;
  localparam int IN_W         = 12;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int SUM_W        = COORD_BITS + ADDR_W + 1;

  // Datapath widths: support point, edge vector, dot product, direction.
  localparam int A_W = COORD_BITS + 1;
  localparam int E_W = COORD_BITS + 2;
  localparam int T_W = 2 * E_W + 1;
  localparam int D_W = T_W + E_W + 1;
  localparam int P_W = D_W + E_W;
  localparam int R_W = P_W + 1;
  localparam int S_W = D_W + COORD_BITS + 1;

  localparam int LIMIT_W = 8;
  localparam int TOTAL_W = 32;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd64;

  typedef enum logic [1:0] {
    STAT_MISS  = 2'd0,
    STAT_HIT   = 2'd1,
    STAT_LIMIT = 2'd2,
    STAT_ERROR = 2'd3
  } status_e;

  typedef struct packed {
    logic                   polygon;
    logic signed [IN_W-1:0] vertex_x;
    logic signed [IN_W-1:0] vertex_y;
    logic                   end_of_query;
  } in_item_t;

  typedef struct packed {
    status_e              status;
    logic [TOTAL_W-1:0]   total_iterations;
  } out_item_t;

  // Vertex store write from the front end.
  typedef struct packed {
    logic                         en;
    logic                         poly;
    logic [ADDR_W-1:0]            addr;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } vtx_wr_t;

  // Query descriptor handed from the front end to the engine.
  typedef struct packed {
    logic                    err;
    logic [CNT_W-1:0]        n1;
    logic [CNT_W-1:0]        n2;
    logic signed [SUM_W-1:0] s1x;
    logic signed [SUM_W-1:0] s1y;
    logic signed [SUM_W-1:0] s2x;
    logic signed [SUM_W-1:0] s2y;
  } query_t;

endpackage

/* src/gjk_front.sv */
module gjk_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  gjk_pkg::in_item_t in_data_i,
  input  logic              busy_i,
  output gjk_pkg::vtx_wr_t  wr_o,
  output logic              cmd_valid_o,
  output gjk_pkg::query_t   cmd_o,
  input  logic              cmd_pop_i
);
  import gjk_pkg::*;

  logic                         acc;
  logic signed [COORD_BITS-1:0] vx, vy;
  logic                         full0, full1;
  logic [CNT_W-1:0]             cnt0_q, cnt1_q, cnt0_d, cnt1_d;
  logic signed [SUM_W-1:0]      s0x_q, s0y_q, s1x_q, s1y_q;
  logic signed [SUM_W-1:0]      s0x_d, s0y_d, s1x_d, s1y_d;
  logic                         ovf_q, ovf_d;
  logic                         cmd_valid_q;
  query_t                       cmd_q;

  // Vertices are held off while a query waits in the queue or runs.
  assign in_stall_o  = cmd_valid_q | busy_i;
  assign acc         = in_valid_i & ~in_stall_o;
  assign vx          = $signed(in_data_i.vertex_x[COORD_BITS-1:0]);
  assign vy          = $signed(in_data_i.vertex_y[COORD_BITS-1:0]);
  assign full0       = (cnt0_q == CNT_W'(MAX_VERTICES));
  assign full1       = (cnt1_q == CNT_W'(MAX_VERTICES));
  assign cmd_valid_o = cmd_valid_q;
  assign cmd_o       = cmd_q;

  // Store write for the accepted vertex, dropped when its store is full.
  always_comb begin
    wr_o.en   = acc & (in_data_i.polygon ? ~full1 : ~full0);
    wr_o.poly = in_data_i.polygon;
    wr_o.addr = in_data_i.polygon ? cnt1_q[ADDR_W-1:0] : cnt0_q[ADDR_W-1:0];
    wr_o.x    = vx;
    wr_o.y    = vy;
  end

  // Running counts and coordinate sums per polygon.
  always_comb begin
    cnt0_d = cnt0_q;
    cnt1_d = cnt1_q;
    s0x_d  = s0x_q;
    s0y_d  = s0y_q;
    s1x_d  = s1x_q;
    s1y_d  = s1y_q;
    ovf_d  = ovf_q;
    if (acc) begin
      if (!in_data_i.polygon) begin
        if (!full0) begin
          cnt0_d = cnt0_q + 1'b1;
          s0x_d  = s0x_q + SUM_W'(vx);
          s0y_d  = s0y_q + SUM_W'(vy);
        end else begin
          ovf_d = 1'b1;
        end
      end else begin
        if (!full1) begin
          cnt1_d = cnt1_q + 1'b1;
          s1x_d  = s1x_q + SUM_W'(vx);
          s1y_d  = s1y_q + SUM_W'(vy);
        end else begin
          ovf_d = 1'b1;
        end
      end
    end
  end

  // On the last vertex the query goes to the queue and the sums restart.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt0_q      <= '0;
      cnt1_q      <= '0;
      s0x_q       <= '0;
      s0y_q       <= '0;
      s1x_q       <= '0;
      s1y_q       <= '0;
      ovf_q       <= 1'b0;
      cmd_valid_q <= 1'b0;
      cmd_q       <= '0;
    end else begin
      if (cmd_pop_i) begin
        cmd_valid_q <= 1'b0;
      end
      if (acc && in_data_i.end_of_query) begin
        cmd_valid_q <= 1'b1;
        cmd_q.err   <= ovf_d | (cnt0_d == '0) | (cnt1_d == '0);
        cmd_q.n1    <= cnt0_d;
        cmd_q.n2    <= cnt1_d;
        cmd_q.s1x   <= s0x_d;
        cmd_q.s1y   <= s0y_d;
        cmd_q.s2x   <= s1x_d;
        cmd_q.s2y   <= s1y_d;
        cnt0_q      <= '0;
        cnt1_q      <= '0;
        s0x_q       <= '0;
        s0y_q       <= '0;
        s1x_q       <= '0;
        s1y_q       <= '0;
        ovf_q       <= 1'b0;
      end else begin
        cnt0_q <= cnt0_d;
        cnt1_q <= cnt1_d;
        s0x_q  <= s0x_d;
        s0y_q  <= s0y_d;
        s1x_q  <= s1x_d;
        s1y_q  <= s1y_d;
        ovf_q  <= ovf_d;
      end
    end
  end

endmodule

/* src/gjk_back.sv */
module gjk_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  gjk_pkg::vtx_wr_t            wr_i,
  input  logic                        cmd_valid_i,
  input  gjk_pkg::query_t             cmd_i,
  output logic                        cmd_pop_o,
  output logic                        busy_o,
  input  logic [gjk_pkg::LIMIT_W-1:0] limit_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output gjk_pkg::out_item_t          out_data_o
);
  import gjk_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_INIT_X, ST_INIT_Y, ST_SCAN_A, ST_SCAN_B, ST_DOT_AD, ST_HEAD,
    ST_L1, ST_L2, ST_L3, ST_L4,
    ST_T1, ST_T2, ST_T3, ST_T4, ST_T5, ST_T6, ST_T7, ST_T8, ST_T9,
    ST_DONE
  } state_e;

  // Vertex stores.
  logic [2*COORD_BITS-1:0] mem_a [MAX_VERTICES];
  logic [2*COORD_BITS-1:0] mem_b [MAX_VERTICES];
  logic [2*COORD_BITS-1:0] rd_q;

  state_e                  state_q;
  logic                    ph_q, first_q, line_q;
  logic [LIMIT_W-1:0]      iters_q;
  logic [TOTAL_W-1:0]      total_q;
  status_e                 stat_q;
  query_t                  q_q;
  logic signed [D_W-1:0]   dx_q, dy_q, px_q, py_q;
  logic signed [T_W-1:0]   t1_q, t2_q;
  logic signed [A_W-1:0]   ax_q, ay_q, s0x_q, s0y_q, s1x_q, s1y_q;
  logic signed [COORD_BITS-1:0] bx_q, by_q, bax_q, bay_q, rx2_q, ry2_q;
  logic signed [P_W-1:0]   p1_q, p2_q;
  logic signed [S_W-1:0]   spx_q, spy_q, best_q;
  logic [CNT_W-1:0]        sc_cnt_q;
  logic                    sc_v1_q, sc_v2_q, best_ok_q;
  logic                    out_valid_q;
  out_item_t               out_q;

  logic signed [E_W-1:0]   ebx, eby, ecx, ecy, aox, aoy;
  logic signed [D_W-1:0]   ma1, ma2;
  logic signed [E_W-1:0]   mb1, mb2;
  logic                    mul_st, sub_op;
  logic signed [R_W-1:0]   res;
  logic signed [D_W-1:0]   res_d;
  logic signed [COORD_BITS-1:0] rdx, rdy;
  logic signed [S_W-1:0]   sp;
  logic [CNT_W-1:0]        sc_n;
  logic                    sc_issue, sc_done, sc_better;

  assign busy_o      = (state_q != ST_IDLE);
  assign cmd_pop_o   = (state_q == ST_IDLE) & cmd_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Edge vectors from the newest point: b is the last point, c the oldest.
  assign ebx = E_W'(s1x_q) - E_W'(ax_q);
  assign eby = E_W'(s1y_q) - E_W'(ay_q);
  assign ecx = E_W'(s0x_q) - E_W'(ax_q);
  assign ecy = E_W'(s0y_q) - E_W'(ay_q);
  assign aox = -E_W'(ax_q);
  assign aoy = -E_W'(ay_q);

  // Operand selection for the two-product step.
  always_comb begin
    mul_st = 1'b1;
    sub_op = 1'b0;
    ma1    = '0;
    mb1    = '0;
    ma2    = '0;
    mb2    = '0;
    unique case (state_q)
      ST_INIT_X: begin
        ma1 = D_W'(q_q.s1x); mb1 = E_W'($signed({1'b0, q_q.n2}));
        ma2 = D_W'(q_q.s2x); mb2 = E_W'($signed({1'b0, q_q.n1})); sub_op = 1'b1;
      end
      ST_INIT_Y: begin
        ma1 = D_W'(q_q.s1y); mb1 = E_W'($signed({1'b0, q_q.n2}));
        ma2 = D_W'(q_q.s2y); mb2 = E_W'($signed({1'b0, q_q.n1})); sub_op = 1'b1;
      end
      ST_DOT_AD: begin
        ma1 = dx_q; mb1 = E_W'(ax_q); ma2 = dy_q; mb2 = E_W'(ay_q);
      end
      ST_L1: begin
        ma1 = D_W'(ecx); mb1 = ecx; ma2 = D_W'(ecy); mb2 = ecy;
      end
      ST_L2: begin
        ma1 = D_W'(ecx); mb1 = aox; ma2 = D_W'(ecy); mb2 = aoy;
      end
      ST_L3: begin
        ma1 = D_W'(t1_q); mb1 = aox; ma2 = D_W'(t2_q); mb2 = ecx; sub_op = 1'b1;
      end
      ST_L4: begin
        ma1 = D_W'(t1_q); mb1 = aoy; ma2 = D_W'(t2_q); mb2 = ecy; sub_op = 1'b1;
      end
      ST_T1: begin
        ma1 = D_W'(ebx); mb1 = ecx; ma2 = D_W'(eby); mb2 = ecy;
      end
      ST_T2: begin
        ma1 = D_W'(ecx); mb1 = ecx; ma2 = D_W'(ecy); mb2 = ecy;
      end
      ST_T3: begin
        ma1 = D_W'(t1_q); mb1 = ecx; ma2 = D_W'(t2_q); mb2 = ebx; sub_op = 1'b1;
      end
      ST_T4: begin
        ma1 = D_W'(t1_q); mb1 = ecy; ma2 = D_W'(t2_q); mb2 = eby; sub_op = 1'b1;
      end
      ST_T5, ST_T9: begin
        ma1 = px_q; mb1 = aox; ma2 = py_q; mb2 = aoy;
      end
      ST_T6: begin
        ma1 = D_W'(ebx); mb1 = ebx; ma2 = D_W'(eby); mb2 = eby;
      end
      ST_T7: begin
        ma1 = D_W'(t1_q); mb1 = ebx; ma2 = D_W'(t2_q); mb2 = ecx; sub_op = 1'b1;
      end
      ST_T8: begin
        ma1 = D_W'(t1_q); mb1 = eby; ma2 = D_W'(t2_q); mb2 = ecy; sub_op = 1'b1;
      end
      default: begin
        mul_st = 1'b0;
      end
    endcase
  end

  assign res   = sub_op ? (R_W'(p1_q) - R_W'(p2_q)) : (R_W'(p1_q) + R_W'(p2_q));
  assign res_d = res[D_W-1:0];

  // Support scan: one stored vertex enters the read/multiply/compare pipe per cycle.
  assign sc_n      = (state_q == ST_SCAN_B) ? q_q.n2 : q_q.n1;
  assign sc_issue  = (sc_cnt_q < sc_n);
  assign sc_done   = ~sc_issue & ~sc_v1_q & ~sc_v2_q;
  assign rdx       = $signed(rd_q[2*COORD_BITS-1:COORD_BITS]);
  assign rdy       = $signed(rd_q[COORD_BITS-1:0]);
  assign sp        = spx_q + spy_q;
  assign sc_better = ~best_ok_q | ((state_q == ST_SCAN_A) ? (sp > best_q) : (sp < best_q));

  // Vertex store write and scan read.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      if (wr_i.poly) begin
        mem_b[wr_i.addr] <= {wr_i.x, wr_i.y};
      end else begin
        mem_a[wr_i.addr] <= {wr_i.x, wr_i.y};
      end
    end
    if ((state_q == ST_SCAN_A || state_q == ST_SCAN_B) && sc_issue) begin
      rd_q <= (state_q == ST_SCAN_B) ? mem_b[sc_cnt_q[ADDR_W-1:0]]
                                     : mem_a[sc_cnt_q[ADDR_W-1:0]];
    end
  end

  // Sequencer and datapath registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ph_q        <= 1'b0;
      first_q     <= 1'b0;
      line_q      <= 1'b0;
      iters_q     <= '0;
      total_q     <= '0;
      stat_q      <= STAT_MISS;
      q_q         <= '0;
      dx_q        <= '0;
      dy_q        <= '0;
      px_q        <= '0;
      py_q        <= '0;
      t1_q        <= '0;
      t2_q        <= '0;
      ax_q        <= '0;
      ay_q        <= '0;
      s0x_q       <= '0;
      s0y_q       <= '0;
      s1x_q       <= '0;
      s1y_q       <= '0;
      bx_q        <= '0;
      by_q        <= '0;
      bax_q       <= '0;
      bay_q       <= '0;
      rx2_q       <= '0;
      ry2_q       <= '0;
      p1_q        <= '0;
      p2_q        <= '0;
      spx_q       <= '0;
      spy_q       <= '0;
      best_q      <= '0;
      sc_cnt_q    <= '0;
      sc_v1_q     <= 1'b0;
      sc_v2_q     <= 1'b0;
      best_ok_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // The result register frees up once its transfer completes.
      if (out_valid_q && !out_stall_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end

      // Products are registered in the first phase, combined in the second.
      if (mul_st) begin
        ph_q <= ~ph_q;
        if (!ph_q) begin
          p1_q <= ma1 * mb1;
          p2_q <= ma2 * mb2;
        end
      end

      unique case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            q_q     <= cmd_i;
            first_q <= 1'b1;
            line_q  <= 1'b1;
            iters_q <= '0;
            ph_q    <= 1'b0;
            if (cmd_i.err) begin
              stat_q  <= STAT_ERROR;
              state_q <= ST_DONE;
            end else begin
              state_q <= ST_INIT_X;
            end
          end
        end
        ST_INIT_X: begin
          if (ph_q) begin
            dx_q    <= res_d;
            state_q <= ST_INIT_Y;
          end
        end
        ST_INIT_Y: begin
          if (ph_q) begin
            dy_q <= res_d;
            if (dx_q == '0 && res_d == '0) begin
              dx_q <= D_W'(1);
            end
            state_q <= ST_SCAN_A;
          end
        end
        ST_SCAN_A, ST_SCAN_B: begin
          if (sc_issue) begin
            sc_cnt_q <= sc_cnt_q + 1'b1;
          end
          sc_v1_q <= sc_issue;
          sc_v2_q <= sc_v1_q;
          if (sc_v1_q) begin
            spx_q <= dx_q * rdx;
            spy_q <= dy_q * rdy;
            rx2_q <= rdx;
            ry2_q <= rdy;
          end
          if (sc_v2_q) begin
            best_ok_q <= 1'b1;
            if (sc_better) begin
              best_q <= sp;
              bx_q   <= rx2_q;
              by_q   <= ry2_q;
            end
          end
          if (sc_done) begin
            sc_cnt_q  <= '0;
            best_ok_q <= 1'b0;
            if (state_q == ST_SCAN_A) begin
              bax_q   <= bx_q;
              bay_q   <= by_q;
              state_q <= ST_SCAN_B;
            end else begin
              ax_q    <= A_W'(bax_q) - A_W'(bx_q);
              ay_q    <= A_W'(bay_q) - A_W'(by_q);
              state_q <= ST_DOT_AD;
            end
          end
        end
        ST_DOT_AD: begin
          if (ph_q) begin
            if (res <= 0) begin
              stat_q  <= STAT_MISS;
              state_q <= ST_DONE;
            end else if (first_q) begin
              dx_q    <= -D_W'(ax_q);
              dy_q    <= -D_W'(ay_q);
              s0x_q   <= ax_q;
              s0y_q   <= ay_q;
              first_q <= 1'b0;
              state_q <= ST_HEAD;
            end else if (line_q) begin
              state_q <= ST_L1;
            end else begin
              state_q <= ST_T1;
            end
          end
        end
        ST_HEAD: begin
          if (iters_q >= limit_i) begin
            stat_q  <= STAT_LIMIT;
            state_q <= ST_DONE;
          end else begin
            iters_q <= iters_q + 1'b1;
            if (total_q != '1) begin
              total_q <= total_q + 1'b1;
            end
            state_q <= ST_SCAN_A;
          end
        end
        // Segment case: new direction is the edge normal toward the origin.
        ST_L1: begin
          if (ph_q) begin
            t1_q    <= res[T_W-1:0];
            state_q <= ST_L2;
          end
        end
        ST_L2: begin
          if (ph_q) begin
            t2_q    <= res[T_W-1:0];
            state_q <= ST_L3;
          end
        end
        ST_L3: begin
          if (ph_q) begin
            dx_q    <= res_d;
            state_q <= ST_L4;
          end
        end
        ST_L4: begin
          if (ph_q) begin
            if (dx_q == '0 && res_d == '0) begin
              dx_q <= -D_W'(ecy);
              dy_q <= D_W'(ecx);
            end else begin
              dy_q <= res_d;
            end
            s1x_q   <= ax_q;
            s1y_q   <= ay_q;
            line_q  <= 1'b0;
            state_q <= ST_HEAD;
          end
        end
        // Triangle case: test the normal of edge ac, then of edge ab.
        ST_T1: begin
          if (ph_q) begin
            t1_q    <= res[T_W-1:0];
            state_q <= ST_T2;
          end
        end
        ST_T2: begin
          if (ph_q) begin
            t2_q    <= res[T_W-1:0];
            state_q <= ST_T3;
          end
        end
        ST_T3: begin
          if (ph_q) begin
            px_q    <= res_d;
            state_q <= ST_T4;
          end
        end
        ST_T4: begin
          if (ph_q) begin
            py_q    <= res_d;
            state_q <= ST_T5;
          end
        end
        ST_T5: begin
          if (ph_q) begin
            if (res >= 0) begin
              dx_q    <= px_q;
              dy_q    <= py_q;
              s1x_q   <= ax_q;
              s1y_q   <= ay_q;
              state_q <= ST_HEAD;
            end else begin
              state_q <= ST_T6;
            end
          end
        end
        ST_T6: begin
          if (ph_q) begin
            t2_q    <= res[T_W-1:0];
            state_q <= ST_T7;
          end
        end
        ST_T7: begin
          if (ph_q) begin
            px_q    <= res_d;
            state_q <= ST_T8;
          end
        end
        ST_T8: begin
          if (ph_q) begin
            py_q    <= res_d;
            state_q <= ST_T9;
          end
        end
        ST_T9: begin
          if (ph_q) begin
            if (res < 0) begin
              stat_q  <= STAT_HIT;
              state_q <= ST_DONE;
            end else begin
              dx_q    <= px_q;
              dy_q    <= py_q;
              s0x_q   <= s1x_q;
              s0y_q   <= s1y_q;
              s1x_q   <= ax_q;
              s1y_q   <= ay_q;
              state_q <= ST_HEAD;
            end
          end
        end
        ST_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q            <= 1'b1;
            out_q.status           <= stat_q;
            out_q.total_iterations <= total_q;
            state_q                <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* src/gjk_convex_polygon_collision.sv */
// Collision test for two convex polygons by 2D GJK on exact integer values.
// Input channel: one vertex per transfer, tagged with its polygon (0 or 1).
// A vertex is taken in every cycle while no query is pending or running.
// The transfer with end_of_query set closes the query and starts the test;
// further vertices are stalled until the engine has finished the query.
// Output channel: one result per query, with the status and the saturating
// total of refinement iterations.
// The start derives the initial direction from the scaled difference of the
// two centroids; each iteration runs the limit check, the two support scans
// (one stored vertex per cycle through a registered read, multiply and
// compare pipe) and up to 10 two-product steps. An empty or overflowed
// query goes straight to the result without running the engine.
// The user writes the iteration limit register (cfg_we_i, cfg_wdata_i) only
// while the block is idle; the block does not enforce it. It resets to 64.
// Reset clears the vertex counts, sums, iteration total and any result.
// While the receiver stalls, the result stays in the output register and the
// engine may finish the next query up to the point of delivering it.
module gjk_convex_polygon_collision (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  gjk_pkg::in_item_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output gjk_pkg::out_item_t          out_data_o,
  input  logic                        cfg_we_i,
  input  logic [gjk_pkg::LIMIT_W-1:0] cfg_wdata_i
);
  import gjk_pkg::*;

  logic [LIMIT_W-1:0] limit_q;
  vtx_wr_t            wr;
  logic               cmd_valid, cmd_pop, busy;
  query_t             cmd;

  // Iteration limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // Front end: vertex loading and query queue.
  gjk_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .busy_i      (busy),
    .wr_o        (wr),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // Back end: vertex stores and GJK engine.
  gjk_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (wr),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .busy_o      (busy),
    .limit_i     (limit_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
